/* rtl/pqrm_pkg.sv */
// Package for the bounded priority queue: sizes, command and status codes.
// Used by the top level priority_queue_remove_max; pqrm_ram does not import it.
`timescale 1ns / 1ps

package pqrm_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int ENTRY_W  = 2 * DATA_W;
  localparam int OCC_W    = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

endpackage

/* rtl/priority_queue_remove_max.sv */
// Bounded priority queue (CAPACITY entries) with first-in tie-break; one result per command.
// Insert, full insert or empty remove: the result is registered from the finish state, and the
// next transaction is taken once the block is back in idle. Remove of n held entries, winner at
// place b: the n entries are scanned on one comparator, then the entries after place b close the
// gap, one entry moved per cycle; the result is then registered from the finish state. A stalled result
// holds the block. Reset (asynchronous, active low) empties the queue; the store is not cleared.
`timescale 1ns / 1ps

module priority_queue_remove_max
  import pqrm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              command_i,
  input  logic signed [31:0] item_value_i,
  input  logic signed [31:0] item_priority_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [31:0] removed_value_o,
  output logic signed [31:0] removed_priority_o,
  output logic [1:0]        status_o,
  output logic [4:0]        occupancy_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COPY   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO_CNT = CNT_W'(2);

  logic [1:0]         state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   rd_q, rd_d;
  logic               pend_q, pend_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  logic [ENTRY_W-1:0] best_q, best_d;
  status_e            res_status_q, res_status_d;

  logic               out_valid_q, out_valid_d;
  logic [DATA_W-1:0]  out_value_q, out_value_d;
  logic [DATA_W-1:0]  out_prio_q, out_prio_d;
  status_e            out_status_q, out_status_d;
  logic [OCC_W-1:0]   out_occ_q, out_occ_d;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               accept;
  logic               take;
  logic               reading;
  logic [IDX_W-1:0]   wr_ptr;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // Entries are stored as {priority, value}.
  pqrm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // During the scan the read data belongs to place rd_q - 1; the first one seeds the best.
  assign take = (rd_q == ONE_CNT) ||
                ($signed(ram_rdata[ENTRY_W-1:DATA_W]) > $signed(best_q[ENTRY_W-1:DATA_W]));
  assign reading = (rd_q < count_q);
  assign wr_ptr  = IDX_W'(rd_q - TWO_CNT);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rd_d         = rd_q;
    pend_d       = pend_q;
    best_idx_d   = best_idx_q;
    best_d       = best_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_prio_d   = out_prio_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[IDX_W-1:0];
    ram_wdata    = {item_priority_i, item_value_i};
    ram_raddr    = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          best_d = '0;
          if (command_i == CMD_INSERT) begin
            state_d = ST_FINISH;
            if (count_q >= CAP_CNT) begin
              res_status_d = STATUS_FULL;
            end else begin
              res_status_d = STATUS_OK;
              ram_we       = 1'b1;
              count_d      = count_q + ONE_CNT;
            end
          end else if (count_q == '0) begin
            res_status_d = STATUS_EMPTY;
            state_d      = ST_FINISH;
          end else begin
            // Place 0 is read at this edge.
            res_status_d = STATUS_OK;
            rd_d         = ONE_CNT;
            state_d      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ram_raddr = rd_q[IDX_W-1:0];
        if (take) begin
          best_d     = ram_rdata;
          best_idx_d = IDX_W'(rd_q - ONE_CNT);
        end
        if (rd_q == count_q) begin
          rd_d    = CNT_W'(best_idx_d) + ONE_CNT;
          pend_d  = 1'b0;
          state_d = ST_COPY;
        end else begin
          rd_d = rd_q + ONE_CNT;
        end
      end
      ST_COPY: begin
        // Each later entry moves one place forward: read at rd_q, write two places back.
        ram_raddr = rd_q[IDX_W-1:0];
        ram_we    = pend_q;
        ram_waddr = wr_ptr;
        ram_wdata = ram_rdata;
        if (reading) begin
          rd_d   = rd_q + ONE_CNT;
          pend_d = 1'b1;
        end else begin
          pend_d  = 1'b0;
          count_d = count_q - ONE_CNT;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_value_d  = best_q[DATA_W-1:0];
          out_prio_d   = best_q[ENTRY_W-1:DATA_W];
          out_status_d = res_status_q;
          out_occ_d    = OCC_W'(count_q);
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_q        <= rd_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q   <= best_idx_d;
    best_q       <= best_d;
    res_status_q <= res_status_d;
    out_value_q  <= out_value_d;
    out_prio_q   <= out_prio_d;
    out_status_q <= out_status_d;
    out_occ_q    <= out_occ_d;
  end

  assign out_valid_o        = out_valid_q;
  assign removed_value_o    = out_value_q;
  assign removed_priority_o = out_prio_q;
  assign status_o           = out_status_q;
  assign occupancy_o        = out_occ_q;

endmodule

/* rtl/pqrm_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Self-contained; no package dependency.
`timescale 1ns / 1ps

module pqrm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
